>>> rtl/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Shared sizes, request and event codes, and the header byte lookup.
// ----------------------------------------------------------------------------
package spd_pkg;

    // Frame layout.
    localparam int PACKET_BYTES = 22;
    localparam int HEADER_BYTES = 4;
    localparam int SUM_LIMIT    = 20;
    localparam int POS_W        = 5;
    localparam int CHK_HI_POS   = PACKET_BYTES - 2;
    localparam int LAST_POS     = PACKET_BYTES - 1;

    // Payload word store: four 32-bit words from offsets 4, 8, 12 and 16.
    localparam int WORD_W      = 32;
    localparam int WORD_SLOTS  = 4;
    localparam int SLOT_W      = 2;
    localparam int CNT_W       = 16;

    // Byte that opens every frame.
    localparam logic [7:0] START_BYTE = 8'h73;

    // Request codes on the input channel.
    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Event codes on the output channel.
    typedef enum logic [1:0] {
        EV_GOOD    = 2'd0,
        EV_BAD_SUM = 2'd1,
        EV_ABORT   = 2'd2
    } t_event;

    // Expected header byte at a given header position.
    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h73;
            2'd1:    val = 8'h6E;
            2'd2:    val = 8'h70;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/spd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports sharing one enable, registered reads.
// ----------------------------------------------------------------------------
module spd_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [DATA_W-1:0]         i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr_b,
    output logic [DATA_W-1:0]         o_rdata_a,
    output logic [DATA_W-1:0]         o_rdata_b
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read ports; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/sensor_packet_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Deframes 22-byte packets from a byte stream, checks the additive checksum,
// emits the four payload words of good packets and keeps saturating counters.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle, including the final byte of a
// packet, while the event stage is empty or can advance; the running sum and
// position counter handle one byte each cycle. A result is registered in the
// event stage and then the output register; words come from reads at bytes 20, 21.
// Reset: synchronous; clears position, counters and pending results, and sets
// sum_length to 19. The word store holds no reset state.
module sensor_packet_deframer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_sum_length,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_data_byte,
    // Output channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_res,
    output logic [31:0] o_word_a,
    output logic [31:0] o_word_b,
    output logic [31:0] o_word_c,
    output logic [31:0] o_word_d,
    output logic [15:0] o_good_total,
    output logic [15:0] o_aborted_total,
    output logic [15:0] o_bad_sum_total
);

    // Configuration and frame state.
    logic [4:0]                  r_sum_len;
    logic [spd_pkg::POS_W-1:0]   r_pos;
    logic [15:0]                 r_sum;
    logic [7:0]                  r_chk_hi;
    logic [23:0]                 r_asm;
    logic [spd_pkg::CNT_W-1:0]   r_good;
    logic [spd_pkg::CNT_W-1:0]   r_abort;
    logic [spd_pkg::CNT_W-1:0]   r_bad;
    logic                        r_ab_load;
    logic [spd_pkg::WORD_W-1:0]  r_word_a;
    logic [spd_pkg::WORD_W-1:0]  r_word_b;

    // Event stage.
    logic                        r_s1_valid;
    spd_pkg::t_event             r_s1_event;
    logic [spd_pkg::CNT_W-1:0]   r_s1_good;
    logic [spd_pkg::CNT_W-1:0]   r_s1_abort;
    logic [spd_pkg::CNT_W-1:0]   r_s1_bad;

    // Output register.
    logic                        r_out_valid;
    spd_pkg::t_event             r_out_event;
    logic [spd_pkg::WORD_W-1:0]  r_out_word_a;
    logic [spd_pkg::WORD_W-1:0]  r_out_word_b;
    logic [spd_pkg::WORD_W-1:0]  r_out_word_c;
    logic [spd_pkg::WORD_W-1:0]  r_out_word_d;
    logic [spd_pkg::CNT_W-1:0]   r_out_good;
    logic [spd_pkg::CNT_W-1:0]   r_out_abort;
    logic [spd_pkg::CNT_W-1:0]   r_out_bad;

    // Next values and decode.
    logic [spd_pkg::POS_W-1:0]   n_pos;
    logic [15:0]                 n_sum;
    logic [spd_pkg::CNT_W-1:0]   n_good;
    logic [spd_pkg::CNT_W-1:0]   n_abort;
    logic [spd_pkg::CNT_W-1:0]   n_bad;
    logic                        n_emit;
    spd_pkg::t_event             n_event;

    logic                        s1_adv;
    logic                        in_acc;
    logic                        data_acc;
    logic                        mid_abort;
    logic [spd_pkg::POS_W-1:0]   p_eff;
    logic                        in_header;
    logic                        hdr_match;
    logic [4:0]                  sum_limit;
    logic [15:0]                 sum_base;
    logic [15:0]                 sum_add;
    logic                        is_last;
    logic                        sum_ok;

    // Word store ports.
    logic                        ram_we;
    logic [spd_pkg::SLOT_W-1:0]  ram_waddr;
    logic [spd_pkg::WORD_W-1:0]  ram_wdata;
    logic                        ram_re;
    logic [spd_pkg::SLOT_W-1:0]  ram_raddr_a;
    logic [spd_pkg::SLOT_W-1:0]  ram_raddr_b;
    logic [spd_pkg::WORD_W-1:0]  ram_rdata_a;
    logic [spd_pkg::WORD_W-1:0]  ram_rdata_b;

    // Handshakes: the event stage moves whenever the output register frees.
    assign s1_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_s1_valid || s1_adv;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign data_acc    = in_acc && (i_req_type == spd_pkg::REQ_DATA);

    // Byte classification against the current frame position.
    always_comb begin
        mid_abort = (i_data_byte == spd_pkg::START_BYTE) && (r_pos != '0);
        p_eff     = mid_abort ? '0 : r_pos;
        in_header = p_eff < spd_pkg::POS_W'(spd_pkg::HEADER_BYTES);
        hdr_match = i_data_byte == spd_pkg::hdr_byte(p_eff[1:0]);
        is_last   = !in_header && (p_eff == spd_pkg::POS_W'(spd_pkg::LAST_POS));
        sum_limit = (r_sum_len > 5'(spd_pkg::SUM_LIMIT)) ? 5'(spd_pkg::SUM_LIMIT)
                                                         : r_sum_len;
        sum_base  = (p_eff == '0) ? 16'd0 : r_sum;
        sum_add   = (p_eff < sum_limit) ? {8'd0, i_data_byte} : 16'd0;
        sum_ok    = r_sum == {r_chk_hi, i_data_byte};
    end

    // Next frame position, running sum, counters and event.
    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_good  = r_good;
        n_abort = r_abort;
        n_bad   = r_bad;
        n_emit  = 1'b0;
        n_event = spd_pkg::EV_ABORT;
        if (in_acc && (i_req_type == spd_pkg::REQ_CLEAR)) begin
            n_good  = '0;
            n_abort = '0;
            n_bad   = '0;
        end else if (data_acc) begin
            if (in_header && !hdr_match) begin
                n_pos = '0;
            end else if (is_last) begin
                n_pos = '0;
            end else begin
                n_pos = p_eff + 1'b1;
                n_sum = sum_base + sum_add;
            end
            if (mid_abort || (in_header && !hdr_match)) begin
                n_emit  = 1'b1;
                n_event = spd_pkg::EV_ABORT;
                n_abort = (r_abort == '1) ? r_abort : r_abort + 1'b1;
            end else if (is_last) begin
                n_emit = 1'b1;
                if (sum_ok) begin
                    n_event = spd_pkg::EV_GOOD;
                    n_good  = (r_good == '1) ? r_good : r_good + 1'b1;
                end else begin
                    n_event = spd_pkg::EV_BAD_SUM;
                    n_bad   = (r_bad == '1) ? r_bad : r_bad + 1'b1;
                end
            end
        end
    end

    // Word store access: a word is written on its fourth byte, words a and b
    // are read at the high checksum byte and words c and d at the last byte.
    always_comb begin
        ram_we      = data_acc && !in_header && (p_eff < 5'(spd_pkg::CHK_HI_POS))
                      && (p_eff[1:0] == 2'd3);
        ram_waddr   = spd_pkg::SLOT_W'(p_eff[4:2] - 3'd1);
        ram_wdata   = {i_data_byte, r_asm};
        ram_re      = 1'b0;
        ram_raddr_a = spd_pkg::SLOT_W'(0);
        ram_raddr_b = spd_pkg::SLOT_W'(1);
        if (data_acc && !in_header && (p_eff == 5'(spd_pkg::CHK_HI_POS))) begin
            ram_re = 1'b1;
        end else if (data_acc && is_last) begin
            ram_re      = 1'b1;
            ram_raddr_a = spd_pkg::SLOT_W'(2);
            ram_raddr_b = spd_pkg::SLOT_W'(3);
        end
    end

    spd_ram #(
        .DATA_W (spd_pkg::WORD_W),
        .DEPTH  (spd_pkg::WORD_SLOTS)
    ) u_word_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re      (ram_re),
        .i_raddr_a (ram_raddr_a),
        .i_raddr_b (ram_raddr_b),
        .o_rdata_a (ram_rdata_a),
        .o_rdata_b (ram_rdata_b)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_len   <= 5'd19;
            r_pos       <= '0;
            r_good      <= '0;
            r_abort     <= '0;
            r_bad       <= '0;
            r_ab_load   <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_sum_len <= i_cfg_sum_length;
            end
            r_pos     <= n_pos;
            r_good    <= n_good;
            r_abort   <= n_abort;
            r_bad     <= n_bad;
            r_ab_load <= ram_re && (ram_raddr_a == spd_pkg::SLOT_W'(0));
            if (in_acc) begin
                r_s1_valid <= n_emit;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Frame data: running sum, checksum high byte, word assembly and held words a, b.
    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
        if (data_acc && !in_header && (p_eff == 5'(spd_pkg::CHK_HI_POS))) begin
            r_chk_hi <= i_data_byte;
        end
        if (data_acc && !in_header) begin
            case (p_eff[1:0])
                2'd0:    r_asm[7:0]   <= i_data_byte;
                2'd1:    r_asm[15:8]  <= i_data_byte;
                2'd2:    r_asm[23:16] <= i_data_byte;
                default: r_asm        <= r_asm;
            endcase
        end
        if (r_ab_load) begin
            r_word_a <= ram_rdata_a;
            r_word_b <= ram_rdata_b;
        end
    end

    // Event stage and output register payload.
    always_ff @(posedge i_clk) begin
        if (in_acc && n_emit) begin
            r_s1_event <= n_event;
            r_s1_good  <= n_good;
            r_s1_abort <= n_abort;
            r_s1_bad   <= n_bad;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_event <= r_s1_event;
            r_out_good  <= r_s1_good;
            r_out_abort <= r_s1_abort;
            r_out_bad   <= r_s1_bad;
            if (r_s1_event == spd_pkg::EV_GOOD) begin
                r_out_word_a <= r_word_a;
                r_out_word_b <= r_word_b;
                r_out_word_c <= ram_rdata_a;
                r_out_word_d <= ram_rdata_b;
            end else begin
                r_out_word_a <= '0;
                r_out_word_b <= '0;
                r_out_word_c <= '0;
                r_out_word_d <= '0;
            end
        end
    end

    // Output ports.
    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_out_event;
    assign o_word_a        = r_out_word_a;
    assign o_word_b        = r_out_word_b;
    assign o_word_c        = r_out_word_c;
    assign o_word_d        = r_out_word_d;
    assign o_good_total    = r_out_good;
    assign o_aborted_total = r_out_abort;
    assign o_bad_sum_total = r_out_bad;

endmodule

>>> rtl/spd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor packet deframer checker
// Port-level properties of the deframer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module spd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_res,
    input logic [31:0] o_word_a,
    input logic [31:0] o_word_b,
    input logic [31:0] o_word_c,
    input logic [31:0] o_word_d,
    input logic [15:0] o_good_total,
    input logic [15:0] o_aborted_total,
    input logic [15:0] o_bad_sum_total
);

    // A stalled output transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // Only good packets carry payload words.
    a_words_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != spd_pkg::EV_GOOD) |->
        (o_word_a == 32'd0) && (o_word_b == 32'd0) &&
        (o_word_c == 32'd0) && (o_word_d == 32'd0))
        else $error("payload words on a failed frame");

    // The counter that matches an event already includes it.
    a_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ((o_event_res == spd_pkg::EV_GOOD) && (o_good_total != 16'd0)) ||
        ((o_event_res == spd_pkg::EV_BAD_SUM) && (o_bad_sum_total != 16'd0)) ||
        ((o_event_res == spd_pkg::EV_ABORT) && (o_aborted_total != 16'd0)))
        else $error("event code and counters disagree");

endmodule

bind sensor_packet_deframer_top spd_checker u_spd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_event_res     (o_event_res),
    .o_word_a        (o_word_a),
    .o_word_b        (o_word_b),
    .o_word_c        (o_word_c),
    .o_word_d        (o_word_d),
    .o_good_total    (o_good_total),
    .o_aborted_total (o_aborted_total),
    .o_bad_sum_total (o_bad_sum_total)
);

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor packet deframer testbench
// Sends directed and random byte streams through the deframer. A built-in
// predictor keeps its own frame store, counters and checksum length, and
// every output transaction is checked field by field against it. The run
// changes idling on both channels and stalls the output for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam int           HALF_PERIOD  = 4;
    localparam int           RESET_CYCLES = 12;
    localparam int           SETTLE       = 16;
    localparam int           SEG_ITEMS    = 330;
    localparam int           HOLD_CYCLES  = 400;
    localparam int           NUM_DIRECTED = 25;
    localparam int           TIMEOUT_NS   = 5_000_000;
    // Header bytes 's', 'n', 'p', 0 packed from position 0 down.
    localparam logic [31:0]  SYNC_WORD    = 32'h736E_7000;

    // One result of the deframer.
    typedef struct packed {
        spd_pkg::t_event ev;
        logic [31:0]     word_a;
        logic [31:0]     word_b;
        logic [31:0]     word_c;
        logic [31:0]     word_d;
        logic [15:0]     good;
        logic [15:0]     aborted;
        logic [15:0]     bad_sum;
    } t_pkt_result;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        logic            req;
        logic [7:0]      data;
        logic            typed;
        spd_pkg::t_event ev;
        logic [15:0]     good;
        logic [15:0]     aborted;
        logic [15:0]     bad_sum;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_sum_length;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_req_type;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_event_res;
    logic [31:0] o_word_a;
    logic [31:0] o_word_b;
    logic [31:0] o_word_c;
    logic [31:0] o_word_d;
    logic [15:0] o_good_total;
    logic [15:0] o_aborted_total;
    logic [15:0] o_bad_sum_total;

    // Predictor state.
    logic [4:0]  sum_len;
    logic [4:0]  frame_pos;
    logic [7:0]  frame [spd_pkg::PACKET_BYTES];
    logic [15:0] good_cnt;
    logic [15:0] abort_cnt;
    logic [15:0] bad_sum_cnt;

    t_pkt_result result_q [$];
    t_pkt_result want;
    t_pkt_result pred;
    t_dir_row    directed_rows [NUM_DIRECTED];

    int err_count;
    int items_sent;
    int clears_sent;
    int results_seen;
    int good_seen;
    int bad_sum_seen;
    int abort_seen;
    int src_idle_pct;
    int snk_idle_pct;
    int rx_hold;

    sensor_packet_deframer_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_sum_length(i_cfg_sum_length),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_res     (o_event_res),
        .o_word_a        (o_word_a),
        .o_word_b        (o_word_b),
        .o_word_c        (o_word_c),
        .o_word_d        (o_word_d),
        .o_good_total    (o_good_total),
        .o_aborted_total (o_aborted_total),
        .o_bad_sum_total (o_bad_sum_total)
    );

    // Free-running clock.
    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Advances the predictor by one input transaction; returns 1 if the
    // transaction produces a result, which is then placed in r.
    function automatic bit deframe_byte(input logic req, input logic [7:0] b,
                                        output t_pkt_result r);
        bit          have;
        int          n;
        logic [15:0] sum;
        have = 1'b0;
        sum  = '0;
        r    = '0;
        if (req == spd_pkg::REQ_CLEAR) begin
            good_cnt    = '0;
            abort_cnt   = '0;
            bad_sum_cnt = '0;
            return 1'b0;
        end
        if (frame_pos >= spd_pkg::PACKET_BYTES) frame_pos = '0;
        // A start byte inside a frame aborts it and then opens a new frame.
        if (b == spd_pkg::START_BYTE && frame_pos != 0) begin
            frame_pos = '0;
            abort_cnt = sat_inc16(abort_cnt);
            have      = 1'b1;
            r.ev      = spd_pkg::EV_ABORT;
        end
        if (frame_pos < spd_pkg::HEADER_BYTES) begin
            if (b == SYNC_WORD[31 - 8 * frame_pos -: 8]) begin
                frame[frame_pos] = b;
                frame_pos++;
            end else begin
                frame_pos = '0;
                abort_cnt = sat_inc16(abort_cnt);
                have      = 1'b1;
                r.ev      = spd_pkg::EV_ABORT;
            end
        end else begin
            frame[frame_pos] = b;
            frame_pos++;
            // The last byte closes the frame and settles the checksum.
            if (frame_pos == spd_pkg::PACKET_BYTES) begin
                n = (sum_len > spd_pkg::SUM_LIMIT) ? spd_pkg::SUM_LIMIT : int'(sum_len);
                for (int i = 0; i < n; i++) sum += 16'(frame[i]);
                frame_pos = '0;
                have      = 1'b1;
                if (sum == {frame[spd_pkg::CHK_HI_POS], frame[spd_pkg::LAST_POS]}) begin
                    good_cnt = sat_inc16(good_cnt);
                    r.ev     = spd_pkg::EV_GOOD;
                    r.word_a = {frame[7], frame[6], frame[5], frame[4]};
                    r.word_b = {frame[11], frame[10], frame[9], frame[8]};
                    r.word_c = {frame[15], frame[14], frame[13], frame[12]};
                    r.word_d = {frame[19], frame[18], frame[17], frame[16]};
                end else begin
                    bad_sum_cnt = sat_inc16(bad_sum_cnt);
                    r.ev        = spd_pkg::EV_BAD_SUM;
                end
            end
        end
        r.good    = good_cnt;
        r.aborted = abort_cnt;
        r.bad_sum = bad_sum_cnt;
        return have;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            err_count++;
        end
    endfunction

    function automatic logic [7:0] payload_byte();
        logic [7:0] v;
        case ($urandom_range(7))
            0:       v = 8'h00;
            1:       v = 8'hFF;
            default: begin
                v = 8'($urandom);
                while (v == spd_pkg::START_BYTE) v = 8'($urandom);
            end
        endcase
        return v;
    endfunction

    // Output monitor: every accepted result is matched with the oldest
    // expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (result_q.size() == 0) begin
                $error("result with no expectation waiting, event_res %0d", o_event_res);
                err_count++;
            end else begin
                want = result_q.pop_front();
                check_field("event_res", 32'(want.ev), 32'(o_event_res));
                check_field("word_a", want.word_a, o_word_a);
                check_field("word_b", want.word_b, o_word_b);
                check_field("word_c", want.word_c, o_word_c);
                check_field("word_d", want.word_d, o_word_d);
                check_field("good_total", 32'(want.good), 32'(o_good_total));
                check_field("aborted_total", 32'(want.aborted), 32'(o_aborted_total));
                check_field("bad_sum_total", 32'(want.bad_sum), 32'(o_bad_sum_total));
                results_seen++;
                case (want.ev)
                    spd_pkg::EV_GOOD:    good_seen++;
                    spd_pkg::EV_BAD_SUM: bad_sum_seen++;
                    default:             abort_seen++;
                endcase
            end
        end
    end

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready = 1'b0;
                rx_hold--;
            end else begin
                i_out_ready = ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Offers one input transaction and waits until it is accepted.
    task automatic accept_item(input logic req, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  = 1'b1;
        i_req_type  = req;
        i_data_byte = b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        items_sent++;
        if (req == spd_pkg::REQ_CLEAR) clears_sent++;
    endtask

    task automatic send_item(input logic req, input logic [7:0] b);
        accept_item(req, b);
        if (deframe_byte(req, b, pred)) result_q.push_back(pred);
    endtask

    // Drops the input valid, waits for all results, then lets the pipeline
    // settle so that the block is idle.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_sum_length(input logic [4:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid      = 1'b1;
        i_cfg_sum_length = v;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        sum_len = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Sends one framed packet with a correct or corrupted checksum. When
    // broken, one byte is replaced by a start byte or a random byte.
    task automatic send_frame(input bit broken);
        logic [7:0]  fr [spd_pkg::PACKET_BYTES];
        logic [15:0] sum;
        int          n;
        int          cut;
        int          clear_at;
        for (int i = 0; i < spd_pkg::HEADER_BYTES; i++) fr[i] = SYNC_WORD[31 - 8 * i -: 8];
        for (int i = spd_pkg::HEADER_BYTES; i < spd_pkg::CHK_HI_POS; i++) begin
            fr[i] = payload_byte();
        end
        n   = (sum_len > spd_pkg::SUM_LIMIT) ? spd_pkg::SUM_LIMIT : int'(sum_len);
        sum = '0;
        for (int i = 0; i < n; i++) sum += 16'(fr[i]);
        if ($urandom_range(3) == 0) sum += 16'($urandom_range(1, 65535));
        fr[spd_pkg::CHK_HI_POS] = sum[15:8];
        fr[spd_pkg::LAST_POS]   = sum[7:0];
        if (broken) begin
            cut     = $urandom_range(1, spd_pkg::LAST_POS);
            fr[cut] = ($urandom_range(1) == 1) ? spd_pkg::START_BYTE : 8'($urandom);
        end
        clear_at = ($urandom_range(19) == 0) ? $urandom_range(0, spd_pkg::LAST_POS) : -1;
        for (int i = 0; i < spd_pkg::PACKET_BYTES; i++) begin
            if (i == clear_at) send_item(spd_pkg::REQ_CLEAR, 8'($urandom));
            send_item(spd_pkg::REQ_DATA, fr[i]);
        end
    endtask

    // Mostly well-formed packets, with broken frames, stray bytes and clears.
    task automatic run_random(input int count);
        int done;
        int pick;
        int k;
        done = 0;
        while (done < count) begin
            pick = $urandom_range(99);
            if (pick < 75) begin
                send_frame(1'b0);
                done += spd_pkg::PACKET_BYTES;
            end else if (pick < 87) begin
                send_frame(1'b1);
                done += spd_pkg::PACKET_BYTES;
            end else if (pick < 96) begin
                k = $urandom_range(1, 4);
                repeat (k) send_item(spd_pkg::REQ_DATA, 8'($urandom));
                done += k;
            end else begin
                send_item(spd_pkg::REQ_CLEAR, 8'($urandom));
                done++;
            end
        end
    endtask

    // Main sequence.
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_sum_length = '0;
        i_in_valid       = 1'b0;
        i_req_type       = spd_pkg::REQ_DATA;
        i_data_byte      = '0;
        err_count        = 0;
        items_sent       = 0;
        clears_sent      = 0;
        results_seen     = 0;
        good_seen        = 0;
        bad_sum_seen     = 0;
        abort_seen       = 0;
        rx_hold          = 0;
        src_idle_pct     = 35;
        snk_idle_pct     = 59;
        sum_len          = 5'd19;
        frame_pos        = '0;
        good_cnt         = '0;
        abort_cnt        = '0;
        bad_sum_cnt      = '0;
        for (int i = 0; i < spd_pkg::PACKET_BYTES; i++) frame[i] = '0;

        // Header and abort cases; counters are easy to follow from reset.
        directed_rows = '{
            '{spd_pkg::REQ_DATA,  8'hFF, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd1, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h00, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd2, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h73, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h6E, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h00, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd3, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h73, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h73, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd4, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h6E, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h70, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h01, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd5, 16'd0},
            '{spd_pkg::REQ_CLEAR, 8'hFF, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h42, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd1, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h73, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h6E, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_CLEAR, 8'h00, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h70, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h00, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h55, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h73, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd1, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h6E, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h70, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h00, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'hFF, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h00, 1'b0, spd_pkg::EV_GOOD,  16'd0, 16'd0, 16'd0},
            '{spd_pkg::REQ_DATA,  8'h73, 1'b1, spd_pkg::EV_ABORT, 16'd0, 16'd2, 16'd0}
        };

        // Synchronous reset, released on a falling clock edge.
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table: typed rows push their own expectation, the rest
        // are predicted.
        foreach (directed_rows[i]) begin
            accept_item(directed_rows[i].req, directed_rows[i].data);
            if (directed_rows[i].typed) begin
                void'(deframe_byte(directed_rows[i].req, directed_rows[i].data, pred));
                pred         = '0;
                pred.ev      = directed_rows[i].ev;
                pred.good    = directed_rows[i].good;
                pred.aborted = directed_rows[i].aborted;
                pred.bad_sum = directed_rows[i].bad_sum;
                result_q.push_back(pred);
            end else if (deframe_byte(directed_rows[i].req, directed_rows[i].data, pred)) begin
                result_q.push_back(pred);
            end
        end

        // Sender idles less than the receiver.
        write_sum_length(5'd20);
        run_random(SEG_ITEMS);
        write_sum_length(5'd1);
        run_random(SEG_ITEMS);

        // Receiver idles less than the sender.
        src_idle_pct = 59;
        snk_idle_pct = 35;
        write_sum_length(5'd0);
        run_random(SEG_ITEMS);
        write_sum_length(5'd31);
        run_random(SEG_ITEMS);

        // No idling from here on.
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_sum_length(5'd19);

        // Long receiver hold-off while stray bytes keep producing results,
        // so the block fills and stalls its input.
        drain_results();
        rx_hold = HOLD_CYCLES;
        repeat (120) send_item(spd_pkg::REQ_DATA, payload_byte());
        while (rx_hold > 0) @(posedge i_clk);

        // Clear the counters, then more random traffic.
        send_item(spd_pkg::REQ_CLEAR, 8'hFF);
        run_random(SEG_ITEMS);

        write_sum_length(5'($urandom_range(2, 18)));
        run_random(SEG_ITEMS);

        // Wait for the last results and watch for stray ones.
        drain_results();
        $display("Sent %0d input transactions (%0d clears); checked %0d results:",
                 items_sent, clears_sent, results_seen);
        $display("  %0d good packets, %0d checksum mismatches, %0d aborted frames.",
                 good_seen, bad_sum_seen, abort_seen);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
